// ===== rtl/maze_wall_map_defines.svh =====
// Assertion macros shared by the wall map RTL.
// Each macro assumes a signal named clock in the calling scope; MWM_ASSERT also needs reset.
`ifndef MAZE_WALL_MAP_DEFINES_SVH
`define MAZE_WALL_MAP_DEFINES_SVH

`ifndef ASSERT_OFF
`define MWM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MWM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MWM_ASSERT(lbl, prop, msg)
`define MWM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/mwm_pkg.sv =====
package mwm_pkg;

   localparam int GRID_SIZE  = 16;
   localparam int GRID_DEPTH = GRID_SIZE * GRID_SIZE;
   localparam int IDX_W      = $clog2(GRID_DEPTH);

   localparam int COORD_W   = 4;
   localparam int HEADING_W = 2;
   localparam int CODE_W    = 2;
   localparam int NUM_SIDES = 4;
   localparam int CELL_W    = NUM_SIDES * CODE_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_UPDATE = 1'b0;

   // Absolute sides.
   localparam logic [1:0] SIDE_EAST  = 2'd0;
   localparam logic [1:0] SIDE_NORTH = 2'd1;
   localparam logic [1:0] SIDE_WEST  = 2'd2;
   localparam logic [1:0] SIDE_SOUTH = 2'd3;

   // Sides relative to the heading.
   localparam logic [1:0] REL_FRONT = 2'd0;
   localparam logic [1:0] REL_LEFT  = 2'd1;
   localparam logic [1:0] REL_BACK  = 2'd2;
   localparam logic [1:0] REL_RIGHT = 2'd3;

   localparam logic [CODE_W-1:0] CODE_UNKNOWN = 2'd0;
   localparam logic [CODE_W-1:0] CODE_WALL    = 2'd1;

   // Cells visited by the back end, in order.
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
   localparam logic [STEP_W-1:0] STEP_EAST   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_NORTH  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_WEST   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_SOUTH  = 3'd4;

   typedef logic [NUM_SIDES-1:0][CODE_W-1:0] code_vec_type;

   typedef struct packed {
      logic                 cmd;
      logic [COORD_W-1:0]   cell_x;
      logic [COORD_W-1:0]   cell_y;
      logic [HEADING_W-1:0] heading;
      code_vec_type         codes;
      logic                 in_grid;
      logic [NUM_SIDES-1:0] nb_en;
   } job_type;

   typedef struct packed {
      logic front_known;
      logic left_known;
      logic right_known;
      logic left_solid;
      logic right_solid;
      logic back_solid;
   } report_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_REPORT
   } bk_state_type;

   function automatic logic [CODE_W-1:0] side_code(input logic [CELL_W-1:0] walls,
                                                  input logic [1:0] side);
      return walls[side*CODE_W +: CODE_W];
   endfunction

endpackage

// ===== rtl/mwm_if.sv =====
interface mwm_req_if
   import mwm_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [COORD_W-1:0]   cell_x;
   logic [COORD_W-1:0]   cell_y;
   logic [HEADING_W-1:0] heading;
   logic [CODE_W-1:0]    front_code;
   logic [CODE_W-1:0]    back_code;
   logic [CODE_W-1:0]    left_code;
   logic [CODE_W-1:0]    right_code;

   modport source (output valid, cmd, cell_x, cell_y, heading, front_code, back_code,
                   left_code, right_code, input ready);
   modport sink (input valid, cmd, cell_x, cell_y, heading, front_code, back_code,
                 left_code, right_code, output ready);
endinterface

interface mwm_rsp_if;
   logic valid;
   logic ready;
   logic front_known;
   logic left_known;
   logic right_known;
   logic left_solid;
   logic right_solid;
   logic back_solid;

   modport source (output valid, front_known, left_known, right_known, left_solid,
                   right_solid, back_solid, input ready);
   modport sink (input valid, front_known, left_known, right_known, left_solid,
                 right_solid, back_solid, output ready);
endinterface

// ===== rtl/mwm_ram.sv =====
module mwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/mwm_front.sv =====
`include "maze_wall_map_defines.svh"

module mwm_front
   import mwm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   mwm_req_if.sink req_port,
   output job_type job,
   output logic    job_valid,
   input  logic    job_pop
);
   job_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   job_type           job_in;
   logic              push;
   logic              pop;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Classify the word: rotate the seen codes to absolute sides and work out
   // which neighbors lie inside the grid.
   always_comb begin
      logic [1:0] rel;
      job_in         = '0;
      job_in.cmd     = req_port.cmd;
      job_in.cell_x  = req_port.cell_x;
      job_in.cell_y  = req_port.cell_y;
      job_in.heading = req_port.heading;
      for (int d = 0; d < NUM_SIDES; d++) begin
         rel = 2'(d) - req_port.heading;
         unique case (rel)
            REL_FRONT: job_in.codes[d] = req_port.front_code;
            REL_LEFT:  job_in.codes[d] = req_port.left_code;
            REL_BACK:  job_in.codes[d] = req_port.back_code;
            REL_RIGHT: job_in.codes[d] = req_port.right_code;
         endcase
      end
      job_in.in_grid = (int'(req_port.cell_x) < GRID_SIZE) &&
                       (int'(req_port.cell_y) < GRID_SIZE);
      job_in.nb_en[SIDE_EAST]  = job_in.in_grid && (int'(req_port.cell_x) + 1 < GRID_SIZE);
      job_in.nb_en[SIDE_NORTH] = job_in.in_grid && (int'(req_port.cell_y) + 1 < GRID_SIZE);
      job_in.nb_en[SIDE_WEST]  = job_in.in_grid && (req_port.cell_x != '0);
      job_in.nb_en[SIDE_SOUTH] = job_in.in_grid && (req_port.cell_y != '0);
   end

   assign req_port.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push           = req_port.valid && req_port.ready;
   assign job_valid      = (count_ff != '0);
   assign pop            = job_pop && job_valid;
   assign job            = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= job_in;
      end
   end

   `MWM_ASSERT(a_count_bound, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
   `MWM_ASSERT(a_count_grows, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1),
               "queue count did not grow on push")
   `MWM_ASSERT(a_full_not_ready, (count_ff == QCNT_W'(QUEUE_DEPTH)) |-> !req_port.ready,
               "queue full but still ready")
endmodule

// ===== rtl/mwm_back.sv =====
`include "maze_wall_map_defines.svh"

module mwm_back
   import mwm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  job_type   job,
   input  logic      job_valid,
   output logic      job_pop,
   mwm_rsp_if.source rsp_port
);
   bk_state_type      state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   job_type           job_ff;

   // Read issue side: the cell chosen by the current step.
   logic              issue;
   logic [IDX_W-1:0]  tgt_addr;
   logic [NUM_SIDES-1:0] tgt_mask;
   code_vec_type      tgt_codes;
   logic              tgt_en;

   // Write side, in the cycle after the read.
   logic              pend_ff, pend_in;
   logic              pend_write_ff, pend_write_in;
   logic              pend_center_ff, pend_center_in;
   logic [IDX_W-1:0]  pend_addr_ff;
   logic [NUM_SIDES-1:0] pend_mask_ff;
   code_vec_type      pend_codes_ff;

   logic [GRID_DEPTH-1:0] valid_ff, valid_in;
   logic              valid_rd_ff;
   logic [CELL_W-1:0] ram_rd_data;
   logic [CELL_W-1:0] old_cell;
   logic [CELL_W-1:0] new_cell;
   logic              ram_wr_en;

   logic [CELL_W-1:0] center_ff, center_in;
   logic              rsp_valid_ff, rsp_valid_in;
   report_type        rsp_ff, rsp_in;
   logic              slot_free;
   logic              rsp_load;

   function automatic logic [IDX_W-1:0] cell_index(input int cx, input int cy);
      return IDX_W'(cy * GRID_SIZE + cx);
   endfunction

   assign slot_free = !rsp_valid_ff || rsp_port.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) state_in = BK_RUN;
         end
         BK_RUN: begin
            if (step_ff == STEP_SOUTH) state_in = BK_REPORT;
         end
         BK_REPORT: begin
            if (slot_free) state_in = job_valid ? BK_RUN : BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      job_pop  = 1'b0;
      issue    = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            job_pop = job_valid;
         end
         BK_RUN: begin
            issue = 1'b1;
         end
         BK_REPORT: begin
            rsp_load = slot_free;
            job_pop  = slot_free && job_valid;
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (job_pop) begin
         step_in = STEP_CENTER;
      end else if (issue) begin
         step_in = step_ff + 1'b1;
      end
   end

   // Pick the cell for this step. A neighbor only gets the facing side.
   always_comb begin
      tgt_addr  = '0;
      tgt_mask  = '0;
      tgt_codes = '0;
      tgt_en    = 1'b0;
      unique case (step_ff)
         STEP_CENTER: begin
            tgt_addr  = cell_index(int'(job_ff.cell_x), int'(job_ff.cell_y));
            tgt_mask  = '1;
            tgt_codes = job_ff.codes;
            tgt_en    = job_ff.in_grid;
         end
         STEP_EAST: begin
            tgt_addr  = cell_index(int'(job_ff.cell_x) + 1, int'(job_ff.cell_y));
            tgt_mask[SIDE_WEST]  = 1'b1;
            tgt_codes[SIDE_WEST] = job_ff.codes[SIDE_EAST];
            tgt_en    = job_ff.nb_en[SIDE_EAST] && (job_ff.cmd == CMD_UPDATE);
         end
         STEP_NORTH: begin
            tgt_addr  = cell_index(int'(job_ff.cell_x), int'(job_ff.cell_y) + 1);
            tgt_mask[SIDE_SOUTH]  = 1'b1;
            tgt_codes[SIDE_SOUTH] = job_ff.codes[SIDE_NORTH];
            tgt_en    = job_ff.nb_en[SIDE_NORTH] && (job_ff.cmd == CMD_UPDATE);
         end
         STEP_WEST: begin
            tgt_addr  = cell_index(int'(job_ff.cell_x) - 1, int'(job_ff.cell_y));
            tgt_mask[SIDE_EAST]  = 1'b1;
            tgt_codes[SIDE_EAST] = job_ff.codes[SIDE_WEST];
            tgt_en    = job_ff.nb_en[SIDE_WEST] && (job_ff.cmd == CMD_UPDATE);
         end
         STEP_SOUTH: begin
            tgt_addr  = cell_index(int'(job_ff.cell_x), int'(job_ff.cell_y) - 1);
            tgt_mask[SIDE_NORTH]  = 1'b1;
            tgt_codes[SIDE_NORTH] = job_ff.codes[SIDE_SOUTH];
            tgt_en    = job_ff.nb_en[SIDE_SOUTH] && (job_ff.cmd == CMD_UPDATE);
         end
         default: begin
            tgt_en = 1'b0;
         end
      endcase
   end

   assign pend_in        = issue && tgt_en;
   assign pend_write_in  = job_ff.cmd == CMD_UPDATE;
   assign pend_center_in = issue && (step_ff == STEP_CENTER);

   mwm_ram #(
      .WIDTH(CELL_W),
      .DEPTH(GRID_DEPTH)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pend_addr_ff),
      .wr_data (new_cell),
      .rd_en   (pend_in),
      .rd_addr (tgt_addr),
      .rd_data (ram_rd_data)
   );

   // A cell never written since reset reads as all unknown.
   assign old_cell  = valid_rd_ff ? ram_rd_data : '0;
   assign ram_wr_en = pend_ff && pend_write_ff;

   always_comb begin
      new_cell = old_cell;
      for (int d = 0; d < NUM_SIDES; d++) begin
         if (pend_write_ff && pend_mask_ff[d] &&
             (old_cell[d*CODE_W +: CODE_W] == CODE_UNKNOWN)) begin
            new_cell[d*CODE_W +: CODE_W] = pend_codes_ff[d];
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ram_wr_en) begin
         valid_in[pend_addr_ff] = 1'b1;
      end
   end

   // An out-of-grid cell reports as all zero.
   assign center_in = pend_ff ? new_cell : '0;

   always_comb begin
      logic [1:0] h;
      h = job_ff.heading;
      rsp_in.front_known = side_code(center_ff, h) != CODE_UNKNOWN;
      rsp_in.left_known  = side_code(center_ff, h + REL_LEFT) != CODE_UNKNOWN;
      rsp_in.right_known = side_code(center_ff, h + REL_RIGHT) != CODE_UNKNOWN;
      rsp_in.left_solid  = side_code(center_ff, h + REL_LEFT) == CODE_WALL;
      rsp_in.right_solid = side_code(center_ff, h + REL_RIGHT) == CODE_WALL;
      rsp_in.back_solid  = side_code(center_ff, h + REL_BACK) == CODE_WALL;
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= STEP_CENTER;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job;
      end
      pend_write_ff  <= pend_write_in;
      pend_center_ff <= pend_center_in;
      pend_addr_ff   <= tgt_addr;
      pend_mask_ff   <= tgt_mask;
      pend_codes_ff  <= tgt_codes;
      if (pend_in) begin
         valid_rd_ff <= valid_ff[tgt_addr];
      end
      if (pend_center_ff) begin
         center_ff <= center_in;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.front_known = rsp_ff.front_known;
   assign rsp_port.left_known  = rsp_ff.left_known;
   assign rsp_port.right_known = rsp_ff.right_known;
   assign rsp_port.left_solid  = rsp_ff.left_solid;
   assign rsp_port.right_solid = rsp_ff.right_solid;
   assign rsp_port.back_solid  = rsp_ff.back_solid;

   `MWM_ASSERT(a_write_only_update, ram_wr_en |-> (job_ff.cmd == CMD_UPDATE),
               "grid written by a report-only word")
   `MWM_ASSERT(a_idle_no_write, (state_ff == BK_IDLE) |-> !ram_wr_en,
               "grid written while idle")
   `MWM_ASSERT(a_rsp_from_report, $rose(rsp_valid_ff) |-> ($past(state_ff) == BK_REPORT),
               "response raised outside the report state")
endmodule

// ===== rtl/maze_wall_map.sv =====
// Wall map of a 16 x 16 maze grid. Each cell keeps four 2-bit wall codes,
// one per absolute side (0 unknown, 1 wall, 2 and 3 open or seen).
// The req channel carries one word per sensing event: a command (update or
// report only), the cell, the heading and the four codes seen relative to the
// heading. An update fills only codes that are still unknown, in the cell and
// in the facing side of each neighbor inside the grid. Every word returns one
// rsp word with the cell's walls relative to the heading, read after the
// update.
// In the back end a word steps through the cell and its four neighbors, reading
// each one inside the grid (only the cell for a report-only word) through the
// single grid RAM read port, with each write in the cycle after its read, and
// then loads the response. The back end takes the next word only while idle
// or as it loads the response of the last one.
// Reset clears the whole grid at once through a valid bit per cell, so the
// block accepts words as soon as reset is released. When the rsp receiver
// stalls, the response register holds and a two-word queue keeps accepting
// requests until it fills, after which req ready drops.
module maze_wall_map
   import mwm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   mwm_req_if.sink   req_port,
   mwm_rsp_if.source rsp_port
);
   job_type job;
   logic    job_valid;
   logic    job_pop;

   mwm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .job       (job),
      .job_valid (job_valid),
      .job_pop   (job_pop)
   );

   mwm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .rsp_port  (rsp_port)
   );
endmodule
